@@ rtl/psg_frame_ring_player_core_assert.svh @@
// Assertion macros used by the RTL back end (psg_frp_back).
`ifndef PSG_FRAME_RING_PLAYER_CORE_ASSERT_SVH
`define PSG_FRAME_RING_PLAYER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psg frame ring player: implication check failed");
`define PFR_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("psg frame ring player: invariant check failed");
`else
`define PFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFR_ASSERT_HOLDS(label, clk, rst_n, expr)
`endif

`endif

@@ rtl/psg_frp_pkg.sv @@
package psg_frp_pkg;

    localparam logic OP_RX_BYTE    = 1'b0;
    localparam logic OP_FRAME_TICK = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] MASK_NIBBLE = 8'h0f;
    localparam logic [7:0] MASK_FIVE   = 8'h1f;
    localparam logic [7:0] MASK_FULL   = 8'hff;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
        logic       last_write;
        logic       refill_request;
    } t_out_item;

    typedef struct packed {
        logic       is_frame;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    function automatic logic [7:0] reg_mask(input logic [3:0] reg_idx);
        logic [7:0] m;
        case (reg_idx)
            4'd1, 4'd3, 4'd5, 4'd13: m = MASK_NIBBLE;
            4'd6, 4'd8, 4'd9, 4'd10: m = MASK_FIVE;
            default:                 m = MASK_FULL;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/psg_frp_ram.sv @@
module psg_frp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/psg_frp_front.sv @@
module psg_frp_front
    import psg_frp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output t_cmd_chan o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_idx, n_wr_idx;
    logic [QUEUE_AW-1:0]   r_rd_idx, n_rd_idx;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  push;
    t_cmd                  cmd_in;

    assign o_in_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push       = i_in_valid && o_in_ready;

    // classify: frame tick or data byte for the ring
    assign cmd_in.is_frame = (i_in_data.opcode == OP_FRAME_TICK);
    assign cmd_in.data     = i_in_data.rx_byte;

    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_mem[r_rd_idx];

    always_comb begin
        n_wr_idx = push ? r_wr_idx + 1'b1 : r_wr_idx;
        n_rd_idx = i_cmd_pop ? r_rd_idx + 1'b1 : r_rd_idx;
        n_count  = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_idx] <= cmd_in;
        end
    end

endmodule

@@ rtl/psg_frp_back.sv @@
`include "psg_frame_ring_player_core_assert.svh"

module psg_frp_back
    import psg_frp_pkg::*;
#(
    parameter int RING_DEPTH     = 512,
    parameter int REGS_PER_FRAME = 14,
    parameter int FRAME_STRIDE   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_chan i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int PW   = $clog2(RING_DEPTH);
    localparam int SKIP = (FRAME_STRIDE > REGS_PER_FRAME) ? FRAME_STRIDE - REGS_PER_FRAME : 0;
    localparam logic [PW:0]   DEPTH_X   = (PW+1)'(RING_DEPTH);
    localparam logic [PW:0]   LAST_STEP = (PW+1)'(SKIP + 1);
    localparam logic [PW:0]   ONE_STEP  = (PW+1)'(1);
    localparam logic [PW-1:0] HALF      = PW'(RING_DEPTH / 2);
    localparam logic [PW-1:0] PTR_MAX   = PW'(RING_DEPTH - 1);
    localparam logic [3:0]    LAST_IDX  = 4'(REGS_PER_FRAME - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

    t_back_state r_state, n_state;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [3:0]    r_reg_idx, n_reg_idx;

    // read stage: RAM output register plus its tags
    logic          r_rd_valid, n_rd_valid;
    logic [3:0]    r_rd_addr, n_rd_addr;
    logic          r_rd_last, n_rd_last;
    logic          r_rd_refill, n_rd_refill;

    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          out_free, rd_free, issue, is_last, refill, ram_we;
    logic [PW:0]   ptr_sum;
    logic [PW-1:0] ptr_next;
    logic [7:0]    ram_rdata;

    assign out_free  = !r_out_valid || i_out_ready;
    assign rd_free   = !r_rd_valid || out_free;
    assign issue     = (r_state == ST_RUN) && rd_free;
    assign is_last   = (r_reg_idx == LAST_IDX);
    assign o_cmd_pop = i_cmd.valid && (r_state == ST_IDLE);
    assign ram_we    = o_cmd_pop && !i_cmd.cmd.is_frame;

    assign ptr_sum  = {1'b0, r_rd_ptr} + (is_last ? LAST_STEP : ONE_STEP);
    assign ptr_next = (ptr_sum >= DEPTH_X) ? PW'(ptr_sum - DEPTH_X) : PW'(ptr_sum);
    assign refill   = (ptr_next == '0) || (ptr_next == HALF);

    psg_frp_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_cmd.cmd.data),
        .i_re   (issue),
        .i_raddr(r_rd_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_reg_idx   = r_reg_idx;
        n_rd_valid  = r_rd_valid;
        n_rd_addr   = r_rd_addr;
        n_rd_last   = r_rd_last;
        n_rd_refill = r_rd_refill;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    if (i_cmd.cmd.is_frame) begin
                        n_state   = ST_RUN;
                        n_reg_idx = '0;
                    end else begin
                        n_wr_ptr = (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_rd_ptr  = ptr_next;
                    n_reg_idx = r_reg_idx + 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (rd_free) begin
            n_rd_valid  = issue;
            n_rd_addr   = r_reg_idx;
            n_rd_last   = is_last;
            n_rd_refill = is_last && refill;
        end

        if (out_free) begin
            n_out_valid = r_rd_valid;
            if (r_rd_valid) begin
                n_out.reg_addr       = r_rd_addr;
                n_out.reg_value      = ram_rdata & reg_mask(r_rd_addr);
                n_out.last_write     = r_rd_last;
                n_out.refill_request = r_rd_refill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_reg_idx   <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_reg_idx   <= n_reg_idx;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_rd_last   <= n_rd_last;
        r_rd_refill <= n_rd_refill;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PFR_ASSERT_IMPL(a_refill_on_last, i_clk, i_rst_n, r_out_valid && r_out.refill_request, r_out.last_write)
    `PFR_ASSERT_IMPL(a_idx_in_frame, i_clk, i_rst_n, r_state == ST_RUN, r_reg_idx <= LAST_IDX)
    `PFR_ASSERT_HOLDS(a_ptrs_in_ring, i_clk, i_rst_n, (r_rd_ptr <= PTR_MAX) && (r_wr_ptr <= PTR_MAX))
    `PFR_ASSERT_IMPL(a_no_pop_in_frame, i_clk, i_rst_n, o_cmd_pop, (r_state == ST_IDLE) && !issue)

endmodule

@@ rtl/psg_frame_ring_player_core.sv @@
// Channel   Dir  Handshake                    Payload
// in        in   i_in_valid / o_in_ready      i_in_data  (opcode, rx_byte)
// out       out  o_out_valid / i_out_ready    o_out_data (reg_addr, reg_value,
//                                                         last_write, refill_request)
// Serial byte: written to the ring by the back end when popped; no output transfer.
// Frame tick: after the pop, REGS_PER_FRAME ring reads on the single RAM read
// port, paused by output stalls; each passes the read stage, then the output register.
// A 4-entry command queue sits between input and back end; input stalls only when full.
// Output stall freezes the read stage and output register; no transfer is lost.
// Reset is synchronous; ring contents are not cleared.
module psg_frame_ring_player_core
    import psg_frp_pkg::*;
#(
    parameter int RING_DEPTH     = 512,
    parameter int REGS_PER_FRAME = 14,
    parameter int FRAME_STRIDE   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd_chan cmd_chan;
    logic      cmd_pop;

    psg_frp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data (i_in_data),
        .o_cmd     (cmd_chan),
        .i_cmd_pop (cmd_pop)
    );

    psg_frp_back #(
        .RING_DEPTH    (RING_DEPTH),
        .REGS_PER_FRAME(REGS_PER_FRAME),
        .FRAME_STRIDE  (FRAME_STRIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_chan),
        .o_cmd_pop  (cmd_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import psg_frp_pkg::*;

    localparam int RING_DEPTH     = 512;
    localparam int REGS_PER_FRAME = 14;
    localparam int FRAME_STRIDE   = 16;
    localparam int PW             = $clog2(RING_DEPTH);
    localparam int SKIP_BYTES     = (FRAME_STRIDE > REGS_PER_FRAME) ?
                                    FRAME_STRIDE - REGS_PER_FRAME : 0;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP      = 10;
    localparam int RAND_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // sound chip registers with narrowed fields
    localparam int R_TONE_A_HI = 1;
    localparam int R_TONE_B_HI = 3;
    localparam int R_TONE_C_HI = 5;
    localparam int R_NOISE     = 6;
    localparam int R_AMP_A     = 8;
    localparam int R_AMP_B     = 9;
    localparam int R_AMP_C     = 10;
    localparam int R_ENV_SHAPE = 13;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data;
        logic       typed;
    } t_dir_row;

    localparam int N_DIR = 17;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{OP_RX_BYTE, 8'h00, 1'b0}, '{OP_RX_BYTE, 8'hff, 1'b0},
        '{OP_RX_BYTE, 8'hff, 1'b0}, '{OP_RX_BYTE, 8'hff, 1'b0},
        '{OP_RX_BYTE, 8'h00, 1'b0}, '{OP_RX_BYTE, 8'hff, 1'b0},
        '{OP_RX_BYTE, 8'hff, 1'b0}, '{OP_RX_BYTE, 8'h00, 1'b0},
        '{OP_RX_BYTE, 8'hff, 1'b0}, '{OP_RX_BYTE, 8'hff, 1'b0},
        '{OP_RX_BYTE, 8'hff, 1'b0}, '{OP_RX_BYTE, 8'h00, 1'b0},
        '{OP_RX_BYTE, 8'hff, 1'b0}, '{OP_RX_BYTE, 8'hff, 1'b0},
        '{OP_FRAME_TICK, 8'h00, 1'b1},
        '{OP_RX_BYTE, 8'h5a, 1'b0}, '{OP_RX_BYTE, 8'ha5, 1'b0}
    };

    // first frame after reset: bytes above through the per-register masks
    localparam logic [7:0] FIRST_FRAME_VALS [REGS_PER_FRAME] = '{
        8'h00, 8'h0f, 8'hff, 8'h0f, 8'h00, 8'h0f, 8'h1f,
        8'h00, 8'h1f, 8'h1f, 8'h1f, 8'h00, 8'hff, 8'h0f
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_ready = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    logic [7:0]    ring_img [RING_DEPTH];
    bit            written [RING_DEPTH];
    logic [PW-1:0] wr_ptr = '0;
    logic [PW-1:0] rd_ptr = '0;
    int            queued_bytes = 0;
    t_out_item     pending_writes [$];
    int            errors = 0;
    int            cycles = 0;
    bit            in_burst = 1'b0;
    bit            out_burst = 1'b0;

    psg_frame_ring_player_core #(
        .RING_DEPTH    (RING_DEPTH),
        .REGS_PER_FRAME(REGS_PER_FRAME),
        .FRAME_STRIDE  (FRAME_STRIDE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [7:0] value_mask(input int r);
        case (r)
            R_TONE_A_HI, R_TONE_B_HI, R_TONE_C_HI, R_ENV_SHAPE: return MASK_NIBBLE;
            R_NOISE, R_AMP_A, R_AMP_B, R_AMP_C:                  return MASK_FIVE;
            default:                                             return MASK_FULL;
        endcase
    endfunction

    // a frame may only read entries the host has already filled
    function automatic bit frame_ready();
        logic [PW-1:0] idx;
        for (int k = 0; k < REGS_PER_FRAME; k++) begin
            idx = rd_ptr + PW'(k);
            if (!written[idx]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void play_item(input t_in_item it, input logic typed);
        t_out_item w;
        if (it.opcode == OP_RX_BYTE) begin
            ring_img[wr_ptr] = it.rx_byte;
            written[wr_ptr]  = 1'b1;
            wr_ptr           = wr_ptr + 1'b1;
            queued_bytes++;
        end else begin
            for (int k = 0; k < REGS_PER_FRAME; k++) begin
                w.reg_addr       = 4'(k);
                w.reg_value      = typed ? FIRST_FRAME_VALS[k] : ring_img[rd_ptr] & value_mask(k);
                w.last_write     = (k == REGS_PER_FRAME - 1);
                w.refill_request = 1'b0;
                rd_ptr           = rd_ptr + 1'b1;
                if (w.last_write) begin
                    rd_ptr           = rd_ptr + PW'(SKIP_BYTES);
                    w.refill_request = (rd_ptr == 0) || (rd_ptr == RING_DEPTH / 2);
                end
                pending_writes.push_back(w);
            end
            queued_bytes -= FRAME_STRIDE;
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_item(input t_in_item it, input logic typed);
        int gap;
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        play_item(it, typed);
    endtask

    initial begin
        t_in_item it;
        int       n_rand;
        bit       tick;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            it.opcode  = DIR_ROWS[i].opcode;
            it.rx_byte = DIR_ROWS[i].data;
            send_item(it, DIR_ROWS[i].typed);
        end

        // mostly full frames of bytes then a tick; some early ticks on stale data
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            if (!frame_ready())
                tick = 1'b0;
            else if (queued_bytes >= FRAME_STRIDE)
                tick = ($urandom_range(0, 3) != 0);
            else
                tick = ($urandom_range(0, 11) == 0);
            it.opcode  = tick ? OP_FRAME_TICK : OP_RX_BYTE;
            it.rx_byte = 8'($urandom_range(0, 255));
            send_item(it, 1'b0);
            n_rand++;
        end
        i_in_valid <= 1'b0;

        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_writes.size() == 0) begin
                flag_mismatch("transfer with nothing pending", 32'(o_out_data), '0);
            end else begin
                want = pending_writes.pop_front();
                if (o_out_data.reg_addr !== want.reg_addr)
                    flag_mismatch("reg_addr", 32'(o_out_data.reg_addr),
                                  32'(want.reg_addr));
                if (o_out_data.reg_value !== want.reg_value)
                    flag_mismatch("reg_value", 32'(o_out_data.reg_value),
                                  32'(want.reg_value));
                if (o_out_data.last_write !== want.last_write)
                    flag_mismatch("last_write", 32'(o_out_data.last_write),
                                  32'(want.last_write));
                if (o_out_data.refill_request !== want.refill_request)
                    flag_mismatch("refill_request", 32'(o_out_data.refill_request),
                                  32'(want.refill_request));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
